### src/value_noise_fbm_top_defines.svh
// value_noise_fbm_top_defines.svh
// assertion macros shared by the checker, no other dependencies
`ifndef VALUE_NOISE_FBM_TOP_DEFINES_SVH
`define VALUE_NOISE_FBM_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define VNF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define VNF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/vnf_pkg.sv
// vnf_pkg.sv
// constants and types for the value noise fbm block, no dependencies
package vnf_pkg;
	localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
	localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

	// data handed from one octave cell to the next
	// acc holds up to nine weighted octaves of 24 bits, so 34 bits
	typedef struct packed {
		logic        vld;
		logic [31:0] x;
		logic [31:0] z;
		logic [33:0] acc;
	} vnf_link_t;
endpackage

### src/vnf_cell.sv
// vnf_cell.sv
// one octave of value noise as a pipeline of small stages, uses vnf_pkg
module vnf_cell import vnf_pkg::*; #(
	parameter int SHIFT = 0,
	parameter int OCT   = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  vnf_link_t li,
	output vnf_link_t lo
);
	localparam int LAT = 8;

	logic [31:0] x0, z0, x1, z1;
	logic [15:0] fx, fz;
	logic [47:0] px, pz;

	assign px = {{16{li.x[31]}}, li.x} << SHIFT;
	assign pz = {{16{li.z[31]}}, li.z} << SHIFT;
	assign x0 = px[47:16];
	assign z0 = pz[47:16];
	assign x1 = x0 + 32'd1;
	assign z1 = z0 + 32'd1;
	assign fx = px[15:0];
	assign fz = pz[15:0];

	// stage 1: corner products and weight squares
	logic [31:0] ax0_s1, ax1_s1, az0_s1, az1_s1;
	logic [31:0] tx2_s1, tz2_s1;
	logic [17:0] kx_s1, kz_s1;
	// stage 2: hash pre-mix and smoothstep
	logic [31:0] h_s2 [4];
	logic [16:0] wx_s2, wz_s2;
	// stage 3: mix multiply
	logic [31:0] m_s3 [4];
	logic [16:0] wx_s3, wz_s3;
	// stage 4/5: row blends
	logic [23:0] v_s4 [4];
	logic [16:0] wx_s4, wz_s4, wz_s5;
	logic [23:0] r0_s5, r1_s5;
	logic [23:0] o_s6;

	// carried data, shift line of LAT deep (acc only needs LAT-1)
	logic [LAT-1:0] vld_q;
	logic [31:0] x_q [LAT];
	logic [31:0] z_q [LAT];
	logic [33:0] acc_q [LAT-1];

	function automatic logic [47:0] blend(input logic [23:0] a, input logic [23:0] b,
			input logic [16:0] s);
		blend = {24'd0, a} * {31'd0, 17'h10000 - s} + {24'd0, b} * {31'd0, s};
	endfunction

	logic [47:0] bl0, bl1, bl2;
	assign bl0 = blend(v_s4[0], v_s4[1], wx_s4);
	assign bl1 = blend(v_s4[2], v_s4[3], wx_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			ax0_s1 <= x0 * HASH_MUL_X;
			ax1_s1 <= x1 * HASH_MUL_X;
			az0_s1 <= z0 * HASH_MUL_Z;
			az1_s1 <= z1 * HASH_MUL_Z;
			tx2_s1 <= {16'd0, fx} * {16'd0, fx};
			tz2_s1 <= {16'd0, fz} * {16'd0, fz};
			kx_s1  <= 18'h30000 - {1'b0, fx, 1'b0};
			kz_s1  <= 18'h30000 - {1'b0, fz, 1'b0};
			h_s2[0] <= ax0_s1 + az0_s1;
			h_s2[1] <= ax1_s1 + az0_s1;
			h_s2[2] <= ax0_s1 + az1_s1;
			h_s2[3] <= ax1_s1 + az1_s1;
			wx_s2 <= 17'((({18'd0, tx2_s1}) * {32'd0, kx_s1}) >> 32);
			wz_s2 <= 17'((({18'd0, tz2_s1}) * {32'd0, kz_s1}) >> 32);
			for (int i = 0; i < 4; i++) begin
				m_s3[i] <= (h_s2[i] ^ (h_s2[i] >> 13)) * HASH_MUL_MIX;
				v_s4[i] <= 24'(m_s3[i] ^ (m_s3[i] >> 16));
			end
			wx_s3 <= wx_s2;
			wz_s3 <= wz_s2;
			wx_s4 <= wx_s3;
			wz_s4 <= wz_s3;
			r0_s5 <= bl0[39:16];
			r1_s5 <= bl1[39:16];
			wz_s5 <= wz_s4;
			o_s6  <= bl2[39:16];
		end
	end
	assign bl2 = blend(r0_s5, r1_s5, wz_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], li.vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q[0] <= li.x;
			z_q[0] <= li.z;
			acc_q[0] <= li.acc;
			for (int i = 1; i < LAT; i++) begin
				x_q[i] <= x_q[i-1];
				z_q[i] <= z_q[i-1];
			end
			for (int i = 1; i < LAT - 1; i++) begin
				acc_q[i] <= acc_q[i-1];
			end
		end
	end

	// o_s6 is held once more in o_s7; add weighted octave value in the last stage
	logic [23:0] o_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			o_s7 <= o_s6;
		end
	end

	logic [33:0] acc_nx;
	assign acc_nx = acc_q[LAT-2] + ({10'd0, o_s7} << (OCT - SHIFT));

	logic [33:0] acc_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s8 <= acc_nx;
		end
	end

	assign lo.vld = vld_q[LAT-1];
	assign lo.x   = x_q[LAT-1];
	assign lo.z   = z_q[LAT-1];
	assign lo.acc = acc_s8;
endmodule

### src/value_noise_fbm_top.sv
// value_noise_fbm_top.sv
// fractal value noise: one request (coord_x, coord_z) gives one noise_sum
// channels: input coord_x/coord_z with valid/stall, output noise_sum with
//   noise_valid/noise_stall; a request is taken when valid is high and stall
//   low at a rising clock edge
// throughput: one request per cycle while the output is not stalled, set by the
//   chain of octave cells which each take a new sample every cycle they advance
// pipeline: the chain of octave cells, each ending in its register acc_s8,
//   then the output registers noise_valid and noise_sum
// stall: the whole chain freezes while the output register holds a result
//   that the receiver stalls; input stall is then raised
// reset: arst_n clears all valid bits, no result is pending after reset
module value_noise_fbm_top import vnf_pkg::*; #(
	parameter int OCTAVES = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_z,
	output logic               noise_valid,
	input  logic               noise_stall,
	output logic signed [17:0] noise_sum
);
	localparam logic [33:0] RND  = 34'd1 << (OCTAVES + 6);
	localparam logic [17:0] BIAS = 18'((32'd1 << (17 - OCTAVES)) * ((32'd1 << OCTAVES) - 1));

	vnf_link_t lk [OCTAVES+1];
	logic adv;

	assign adv   = !(noise_valid && noise_stall);
	assign stall = !adv;

	assign lk[0].vld = valid && adv;
	assign lk[0].x   = coord_x;
	assign lk[0].z   = coord_z;
	assign lk[0].acc = '0;

	for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
		vnf_cell #(.SHIFT(g), .OCT(OCTAVES)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv), .li(lk[g]), .lo(lk[g+1])
		);
	end

	logic [33:0] rsum;
	assign rsum = (lk[OCTAVES].acc + RND) >> (OCTAVES + 7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_valid <= 1'b0;
		end else if (adv) begin
			noise_valid <= lk[OCTAVES].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			noise_sum <= $signed(rsum[17:0] - BIAS);
		end
	end
endmodule

### src/vnf_checker.sv
// vnf_checker.sv
// port-level checks for value_noise_fbm_top, uses the defines header
`include "value_noise_fbm_top_defines.svh"
module vnf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               stall,
	input logic               noise_valid,
	input logic               noise_stall,
	input logic signed [17:0] noise_sum
);
	`VNF_ASSERT_NEXT(a_out_hold, noise_valid && noise_stall, noise_valid && $stable(noise_sum))
	`VNF_ASSERT_IMPL(a_stall_src, stall, noise_valid && noise_stall)
	`VNF_ASSERT_IMPL(a_range, noise_valid, noise_sum >= -18'sd126976 && noise_sum <= 18'sd126976)
endmodule

bind value_noise_fbm_top vnf_checker u_vnf_checker (
	.clk(clk), .arst_n(arst_n), .stall(stall),
	.noise_valid(noise_valid), .noise_stall(noise_stall), .noise_sum(noise_sum)
);

### tb/sv/value_noise_fbm_top_tb.sv
// value_noise_fbm_top_tb.sv
// self-checking bench for value_noise_fbm_top: predicts each noise sum from the
// coordinates and compares it with the output stream; depends on vnf_pkg and the rtl
`timescale 1ns / 100ps

module value_noise_fbm_top_tb import vnf_pkg::*;;

	localparam int NUM_OCT = 5;
	localparam int LATENCY = 8 * NUM_OCT + 1;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] z;
	} point_t;

	logic               clk;
	logic               arst_n;
	logic               valid;
	logic               stall;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_z;
	logic               noise_valid;
	logic               noise_stall;
	logic signed [17:0] noise_sum;

	point_t             pending_points[$];
	logic signed [17:0] expected_sums[$];
	int                 error_count = 0;
	int                 src_idle_pct;
	int                 dst_idle_pct;
	bit                 hold_src;
	bit                 src_done;
	bit                 in_taken;
	int                 idle_cycles;

	value_noise_fbm_top #(.OCTAVES(NUM_OCT)) i_dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.coord_x(coord_x), .coord_z(coord_z), .noise_valid(noise_valid),
		.noise_stall(noise_stall), .noise_sum(noise_sum)
	);

	function automatic logic [23:0] lattice_hash(logic [31:0] xi, logic [31:0] zi);
		logic [31:0] h;
		h = xi * HASH_MUL_X + zi * HASH_MUL_Z;
		h = (h ^ (h >> 13)) * HASH_MUL_MIX;
		h = h ^ (h >> 16);
		return h[23:0];
	endfunction

	function automatic logic [63:0] fade16(logic [63:0] t);
		return ((t * t) * ((64'd3 << 16) - 2 * t)) >> 32;
	endfunction

	function automatic logic [63:0] mix24(logic [63:0] a, logic [63:0] b, logic [63:0] s);
		return (a * (64'd65536 - s) + b * s) >> 16;
	endfunction

	function automatic logic signed [17:0] fbm_sum(point_t p);
		logic [63:0] sx, sz, px, pz, wx, wz, r0, r1, acc, bias;
		logic [31:0] x0, z0;
		acc = 0;
		sx = {{32{p.x[31]}}, p.x};
		sz = {{32{p.z[31]}}, p.z};
		for (int i = 0; i < NUM_OCT; i++) begin
			px = sx << i;
			pz = sz << i;
			x0 = px[47:16];
			z0 = pz[47:16];
			wx = fade16({48'd0, px[15:0]});
			wz = fade16({48'd0, pz[15:0]});
			r0 = mix24(lattice_hash(x0, z0), lattice_hash(x0 + 1, z0), wx);
			r1 = mix24(lattice_hash(x0, z0 + 1), lattice_hash(x0 + 1, z0 + 1), wx);
			acc += mix24(r0, r1, wz) << (NUM_OCT - i);
		end
		bias = (64'd1 << (17 - NUM_OCT)) * ((64'd1 << NUM_OCT) - 1);
		acc = ((acc + (64'd1 << (NUM_OCT + 6))) >> (NUM_OCT + 7)) - bias;
		return acc[17:0];
	endfunction

	task automatic report_mismatch(logic signed [17:0] got, logic signed [17:0] want);
		$display("noise_sum %0d, predicted %0d at %0t", got, want, $time);
		error_count++;
	endtask

	task automatic add_point(logic [31:0] x, logic [31:0] z);
		point_t p;
		p.x = x;
		p.z = z;
		pending_points.push_back(p);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// request accepted at the rising edge
	always @(posedge clk) begin
		in_taken <= arst_n && valid && !stall;
		if (arst_n && valid && !stall) begin
			expected_sums.push_back(fbm_sum('{coord_x, coord_z}));
			void'(pending_points.pop_front());
		end
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid   <= 0;
			coord_x <= 0;
			coord_z <= 0;
		end else begin
			if (!valid || in_taken) begin
				if (pending_points.size() != 0 && !hold_src
					&& ($urandom_range(99) >= src_idle_pct)) begin
					valid   <= 1;
					coord_x <= pending_points[0].x;
					coord_z <= pending_points[0].z;
				end else begin
					valid <= 0;
				end
			end
		end
	end

	// receiver stall, changed at the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			noise_stall <= 0;
		else
			noise_stall <= ($urandom_range(99) < dst_idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && noise_valid && !noise_stall) begin
			if (expected_sums.size() == 0) begin
				$display("unexpected noise_sum %0d at %0t", noise_sum, $time);
				error_count++;
			end else if (noise_sum !== expected_sums[0]) begin
				report_mismatch(noise_sum, expected_sums.pop_front());
			end else begin
				void'(expected_sums.pop_front());
			end
		end
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if (!arst_n || (valid && !stall) || (noise_valid && !noise_stall) || src_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("value_noise_fbm_top: mismatch");
			$finish;
		end
	end

	task automatic drain_inputs();
		while (pending_points.size() != 0 || valid)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0] rx, rz;
		src_idle_pct = 38;
		dst_idle_pct = 45;
		hold_src     = 0;
		src_done     = 0;
		arst_n       = 0;
		repeat (8) @(posedge clk);
		arst_n = 0;
		@(negedge clk);
		arst_n = 1;

		// extremes, sign boundaries, cell edges and wrap of the lattice index
		add_point(32'h0000_0000, 32'h0000_0000);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_point(32'h8000_0000, 32'h8000_0000);
		add_point(32'h7FFF_FFFF, 32'h8000_0000);
		add_point(32'h8000_0000, 32'h7FFF_FFFF);
		add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_point(32'h0000_FFFF, 32'h0000_FFFF);
		add_point(32'h0001_0000, 32'hFFFF_0000);
		add_point(32'hFFFF_8000, 32'h0000_8000);
		add_point(32'h7FFF_0000, 32'h7FFF_FFFF);
		add_point(32'h4000_0000, 32'hC000_0000);
		add_point(32'h0000_0001, 32'hFFFF_FFFE);
		add_point(32'h0123_4567, 32'hFEDC_BA98);
		add_point(32'hAAAA_AAAA, 32'h5555_5555);
		add_point(32'h5555_5555, 32'hAAAA_AAAA);
		for (int n = 0; n < 1100; n++) begin
			rx = $urandom;
			rz = $urandom;
			if ($urandom_range(3) == 0) begin
				// small coordinates near the origin
				rx = $signed(rx) >>> 12;
				rz = $signed(rz) >>> 12;
			end
			add_point(rx, rz);
			if (n == 360) begin
				drain_inputs();
				// hold the sender until every result is back
				hold_src = 1;
				while (expected_sums.size() != 0)
					@(posedge clk);
				hold_src     = 0;
				src_idle_pct = 45;
				dst_idle_pct = 38;
			end
			if (n == 730) begin
				drain_inputs();
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
		end
		drain_inputs();
		while (expected_sums.size() != 0)
			@(posedge clk);
		src_done = 1;
		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0 && expected_sums.size() == 0)
			$display("value_noise_fbm_top: match");
		else
			$display("value_noise_fbm_top: mismatch");
		$finish;
	end
endmodule
